FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ARD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ard check failed");

// next-cycle implication
`define ARD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ard check failed");

`endif

FILE: hdl/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg
// shared types and constants of the altimeter record decoder
// ----------------------------------------------------------------------------
package ard_pkg;

    localparam logic [7:0]  ARD_FILL_BYTE = 8'hFF;
    localparam logic [15:0] ARD_TEMP_BASE = 16'd2560;

    // configuration register indexes
    localparam logic [1:0] ARD_CFG_WINDOW  = 2'd0;
    localparam logic [1:0] ARD_CFG_OUTLIER = 2'd1;
    localparam logic [1:0] ARD_CFG_TICK    = 2'd2;

    localparam logic [6:0] ARD_WINDOW_RST  = 7'd0;
    localparam logic [9:0] ARD_OUTLIER_RST = 10'd320;
    localparam logic [9:0] ARD_TICK_RST    = 10'd25;

    // record queue between front and back
    localparam int ARD_QDEPTH = 2;

    typedef struct packed {
        logic [6:0] window_size;
        logic [9:0] outlier_limit;
        logic [9:0] tick_ms;
    } t_cfg;

    typedef struct packed {
        logic               new_flight;
        logic signed [19:0] alt;
        logic [15:0]        temp;
    } t_rec;

endpackage

FILE: hdl/ard_front.sv
// ----------------------------------------------------------------------------
// ard_front
// byte assembler: builds five-byte records, detects flight boundaries and
// pre-decodes raw altitude and temperature
// ----------------------------------------------------------------------------
module ard_front import ard_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_q_full,
    output logic       o_stall,
    output logic       o_push,
    output t_rec       o_rec
);

    logic [7:0]         r_held [4];
    logic [2:0]         r_pos;
    logic               r_skip;
    logic               r_newf;

    logic               accept;
    logic               is_last;
    logic               all_fill;
    logic signed [15:0] alt_int;
    logic [7:0]         frac;
    logic [11:0]        temp_c;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign is_last = !r_skip && (r_pos == 3'd4);

    always_comb begin
        all_fill = (r_held[0] == ARD_FILL_BYTE) && (r_held[1] == ARD_FILL_BYTE) &&
                   (r_held[2] == ARD_FILL_BYTE) && (r_held[3] == ARD_FILL_BYTE) &&
                   (i_data_byte == ARD_FILL_BYTE);
        alt_int  = {r_held[0], r_held[1]};
        // fraction byte is complemented for negative values
        frac     = alt_int[15] ? ~r_held[2] : r_held[2];
        temp_c   = {r_held[3], i_data_byte[7:4]};
        o_rec.new_flight = r_newf;
        o_rec.alt        = {alt_int, frac[7:4]};
        o_rec.temp       = ARD_TEMP_BASE + {1'b0, temp_c, 3'b000} + {4'b0000, temp_c};
        o_push           = accept && is_last && !all_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 3'd0;
            r_skip <= 1'b0;
            r_newf <= 1'b0;
        end else if (accept) begin
            if (r_skip) begin
                if (i_data_byte != ARD_FILL_BYTE) begin
                    r_skip <= 1'b0;
                    r_newf <= 1'b1;
                    r_pos  <= 3'd1;
                end
            end else if (r_pos != 3'd4) begin
                r_pos <= r_pos + 3'd1;
            end else begin
                r_pos <= 3'd0;
                if (all_fill) begin
                    r_skip <= 1'b1;
                end else begin
                    r_newf <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_skip) begin
                r_held[0] <= i_data_byte;
            end else if (r_pos != 3'd4) begin
                r_held[r_pos[1:0]] <= i_data_byte;
            end
        end
    end

endmodule

FILE: hdl/ard_fifo.sv
// ----------------------------------------------------------------------------
// ard_fifo
// short record queue between the byte front and the record back end
// ----------------------------------------------------------------------------
module ard_fifo import ard_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_rec o_rec
);

    localparam int QAW = (ARD_QDEPTH > 1) ? $clog2(ARD_QDEPTH) : 1;

    t_rec           r_mem [ARD_QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QAW+1)'(ARD_QDEPTH));
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

FILE: hdl/ard_back.sv
// ----------------------------------------------------------------------------
// ard_back
// record processor: outlier filter, moving window, radix-4 average divider,
// flight counters and the result register
// ----------------------------------------------------------------------------
module ard_back import ard_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_rec               i_rec,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [31:0]        o_elapsed_time,
    output logic signed [19:0] o_altitude,
    output logic [15:0]        o_temperature_f,
    output logic signed [23:0] o_average_altitude,
    output logic               o_average_valid,
    output logic [15:0]        o_flight_index,
    output logic               o_first_of_flight
);

    localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WCAP = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_FILT = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic signed [19:0] r_win [MAX_WINDOW];

    logic [2:0]         r_state;
    logic [31:0]        r_time;
    logic [31:0]        r_count;
    logic [15:0]        r_flight;
    logic signed [19:0] r_prev;
    logic [PW-1:0]      r_ptr;
    logic [26:0]        r_sum;
    logic               r_ov;

    logic signed [19:0] r_alt_raw;
    logic [15:0]        r_temp;
    logic signed [19:0] r_rd;
    logic signed [19:0] r_alt;
    logic               r_avg_ok;
    logic               r_neg;
    logic [31:0]        r_quo;
    logic [6:0]         r_rem;
    logic [3:0]         r_iter;

    logic [31:0]        r_o_time;
    logic signed [19:0] r_o_alt;
    logic [15:0]        r_o_temp;
    logic signed [23:0] r_o_avg;
    logic               r_o_avg_ok;
    logic [15:0]        r_o_flight;
    logic               r_o_first;

    logic [6:0]         w;
    logic               win_on;
    logic               win_full;
    logic signed [20:0] diff;
    logic [20:0]        adiff;
    logic               jump;
    logic signed [19:0] alt_f;
    logic [26:0]        sum_n;
    logic [31:0]        n_num;
    logic [31:0]        n_abs;
    logic [PW:0]        ptr_inc;
    logic [PW-1:0]      n_ptr;
    logic [7:0]         rem_a;
    logic               ge_a;
    logic [7:0]         rem_a2;
    logic [7:0]         rem_b;
    logic               ge_b;
    logic [7:0]         rem_b2;
    logic [31:0]        q_adj;
    logic [31:0]        avg_full;

    always_comb begin
        w        = (i_cfg.window_size > 7'(WCAP)) ? 7'(WCAP) : i_cfg.window_size;
        win_on   = (w != 7'd0);
        win_full = (r_count >= {25'd0, w});
        o_pop    = (r_state == ST_IDLE) && i_q_valid && !r_ov;

        // outlier test once the flight has settled
        diff  = {r_alt_raw[19], r_alt_raw} - {r_prev[19], r_prev};
        adiff = diff[20] ? 21'(-diff) : 21'(diff);
        jump  = (r_count > {25'd0, w}) && (adiff > {11'd0, i_cfg.outlier_limit});
        alt_f = jump ? r_prev : r_alt_raw;

        sum_n = r_sum + {{7{r_alt[19]}}, r_alt};
        if (win_full) begin
            sum_n = sum_n - {{7{r_rd[19]}}, r_rd};
        end

        ptr_inc = {1'b0, r_ptr} + (PW+1)'(1);
        n_ptr   = (int'(ptr_inc) >= int'(w)) ? '0 : ptr_inc[PW-1:0];

        // dividend is sum * 16, divided as a magnitude
        n_num = {r_sum[26], r_sum, 4'b0000};
        n_abs = r_sum[26] ? (~n_num + 32'd1) : n_num;

        // two restoring steps per cycle
        rem_a  = {r_rem, r_quo[31]};
        ge_a   = (rem_a >= {1'b0, w});
        rem_a2 = ge_a ? (rem_a - {1'b0, w}) : rem_a;
        rem_b  = {rem_a2[6:0], r_quo[30]};
        ge_b   = (rem_b >= {1'b0, w});
        rem_b2 = ge_b ? (rem_b - {1'b0, w}) : rem_b;

        // floor for negative dividends
        q_adj    = r_quo + {31'd0, (r_rem != 7'd0)};
        avg_full = r_neg ? (~q_adj + 32'd1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_time   <= 32'd0;
            r_count  <= 32'd0;
            r_flight <= 16'd1;
            r_prev   <= '0;
            r_ptr    <= '0;
            r_sum    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == ST_OUT) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_rec.new_flight) begin
                            r_time   <= 32'd0;
                            r_count  <= 32'd0;
                            r_ptr    <= '0;
                            r_sum    <= '0;
                            r_flight <= (r_flight == 16'hFFFF) ? 16'd1 : r_flight + 16'd1;
                        end
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_FILT;
                end
                ST_FILT: begin
                    r_prev  <= alt_f;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (win_on) begin
                        r_sum <= sum_n;
                        r_ptr <= n_ptr;
                    end
                    r_state <= r_avg_ok ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    if (r_iter == 4'd15) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_time  <= r_time + {22'd0, i_cfg.tick_ms};
                    if (r_count != 32'hFFFF_FFFF) begin
                        r_count <= r_count + 32'd1;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_win[r_ptr];
        if (r_state == ST_UPD && win_on) begin
            r_win[r_ptr] <= r_alt;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_alt_raw <= i_rec.alt;
                    r_temp    <= i_rec.temp;
                end
            end
            ST_FILT: begin
                r_alt    <= alt_f;
                r_avg_ok <= win_on && win_full;
            end
            ST_UPD: begin
                r_quo  <= n_abs;
                r_rem  <= 7'd0;
                r_iter <= 4'd0;
                r_neg  <= r_sum[26];
            end
            ST_DIV: begin
                r_quo  <= {r_quo[29:0], ge_a, ge_b};
                r_rem  <= rem_b2[6:0];
                r_iter <= r_iter + 4'd1;
            end
            ST_OUT: begin
                r_o_time   <= r_time;
                r_o_alt    <= r_alt;
                r_o_temp   <= r_temp;
                r_o_avg    <= r_avg_ok ? avg_full[23:0] : 24'd0;
                r_o_avg_ok <= r_avg_ok;
                r_o_flight <= r_flight;
                r_o_first  <= (r_count == 32'd0);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid        = r_ov;
    assign o_elapsed_time     = r_o_time;
    assign o_altitude         = r_o_alt;
    assign o_temperature_f    = r_o_temp;
    assign o_average_altitude = r_o_avg;
    assign o_average_valid    = r_o_avg_ok;
    assign o_flight_index     = r_o_flight;
    assign o_first_of_flight  = r_o_first;

endmodule

FILE: hdl/altimeter_record_decoder_top.sv
// ----------------------------------------------------------------------------
// altimeter_record_decoder_top
// logger byte stream to decoded altitude records with flight tracking
// ----------------------------------------------------------------------------
// throughput: one byte per cycle, while the queue is not full, into a
//   two-record queue; the back end takes one record at a time, only when idle
//   and the last result has been taken (divider: two quotient bits per cycle)
// path: the fifth byte of a record pushes it into the queue; the back end then
//   steps through read, filter, update, divide (with a valid average) and output
// reset: synchronous active low, clears control state; window memory is not
module altimeter_record_decoder_top import ard_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_elapsed_time,
    output logic signed [19:0] o_altitude,
    output logic [15:0]        o_temperature_f,
    output logic signed [23:0] o_average_altitude,
    output logic               o_average_valid,
    output logic [15:0]        o_flight_index,
    output logic               o_first_of_flight
);

    t_cfg r_cfg;
    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    t_rec front_rec;
    t_rec head_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size   <= ARD_WINDOW_RST;
            r_cfg.outlier_limit <= ARD_OUTLIER_RST;
            r_cfg.tick_ms       <= ARD_TICK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ARD_CFG_WINDOW:  r_cfg.window_size   <= i_cfg_wdata[6:0];
                ARD_CFG_OUTLIER: r_cfg.outlier_limit <= i_cfg_wdata;
                ARD_CFG_TICK:    r_cfg.tick_ms       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ard_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_stall     (o_in_stall),
        .o_push      (q_push),
        .o_rec       (front_rec)
    );

    ard_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (front_rec),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_rec   (head_rec)
    );

    ard_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_valid          (q_valid),
        .i_rec              (head_rec),
        .o_pop              (q_pop),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_elapsed_time     (o_elapsed_time),
        .o_altitude         (o_altitude),
        .o_temperature_f    (o_temperature_f),
        .o_average_altitude (o_average_altitude),
        .o_average_valid    (o_average_valid),
        .o_flight_index     (o_flight_index),
        .o_first_of_flight  (o_first_of_flight)
    );

endmodule

FILE: hdl/ard_checker.sv
// ----------------------------------------------------------------------------
// ard_checker
// port-level checks of the decoder results, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ard_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input logic [31:0]        i_elapsed_time,
    input logic signed [19:0] i_altitude,
    input logic signed [23:0] i_average_altitude,
    input logic               i_average_valid,
    input logic [15:0]        i_flight_index,
    input logic               i_first_of_flight
);

    // a flight starts at time zero
    `ARD_ASSERT_IMP(a_first_time_zero, i_out_valid && i_first_of_flight, i_elapsed_time == 32'd0)
    `ARD_ASSERT_IMP(a_avg_zero, i_out_valid && !i_average_valid, i_average_altitude == 24'sd0)
    // flight number skips zero on wrap
    `ARD_ASSERT_IMP(a_flight_nonzero, i_out_valid, i_flight_index != 16'd0)
    `ARD_ASSERT_NXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_altitude))
    `ARD_ASSERT_NXT(a_time_hold, i_out_valid && i_out_stall, $stable(i_elapsed_time))

endmodule

bind altimeter_record_decoder_top ard_checker u_ard_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .i_elapsed_time     (o_elapsed_time),
    .i_altitude         (o_altitude),
    .i_average_altitude (o_average_altitude),
    .i_average_valid    (o_average_valid),
    .i_flight_index     (o_flight_index),
    .i_first_of_flight  (o_first_of_flight)
);
